/* rtl/cbmt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbmt_pkg
// Shared types and constants of the credit buffered memory target.
// ----------------------------------------------------------------------------
package cbmt_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int STORE_BYTES_DEF = 256;
  localparam int LIMIT_RST       = 3;   // buffer_limit after reset
  localparam int BYTES_MAX       = 4;   // longest access
  localparam int CNT_W           = 4;   // credit, count and limit width

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_NO_CREDIT = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_COMPLETED = 3'd3,
    ST_NOTHING   = 3'd4,
    ST_RANGE     = 3'd5
  } status_e;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_DRAIN   = 1'b1;

  // one queued request
  typedef struct packed {
    logic        is_write;
    logic [7:0]  addr;
    logic [2:0]  length;
    logic [31:0] wdata;
  } req_t;

  // controller -> datapath
  typedef struct packed {
    logic    clr_step;   // clear one store byte
    logic    spend;      // take one credit
    logic    enq;        // push request
    logic    pop;        // pop oldest request, return credit
    logic    byte_step;  // access one byte of the popped request
    logic    emit;       // load result registers
    logic    emit_pop;   // result belongs to a popped request
    status_e emit_st;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic credit_zero;
    logic q_empty;
    logic q_full;
    logic clr_last;
    logic range_err;
    logic len_zero;
    logic byte_last;
    logic ent_write;
  } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/cbmt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbmt_ctrl
// Sequencer: store clear pass, request handling, drain byte loop.
// ----------------------------------------------------------------------------
module cbmt_ctrl
  import cbmt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire logic     cmd_i,
  input  wire dp_sts_t  sts_i,
  output logic          busy,
  output ctl_cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_FETCH  = 5'b00100,
    S_ACCESS = 5'b01000,
    S_TAIL   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_st = ST_QUEUED;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (cmd_i == CMD_REQUEST) begin
            cmd_o.emit = 1'b1;
            if (sts_i.credit_zero) begin
              cmd_o.emit_st = ST_NO_CREDIT;
            end else begin
              cmd_o.spend = 1'b1;
              if (sts_i.q_full) begin
                cmd_o.emit_st = ST_OVERFLOW;
              end else begin
                cmd_o.enq     = 1'b1;
                cmd_o.emit_st = ST_QUEUED;
              end
            end
          end else if (sts_i.q_empty) begin
            cmd_o.emit    = 1'b1;
            cmd_o.emit_st = ST_NOTHING;
          end else begin
            cmd_o.pop = 1'b1;
            state_d   = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (sts_i.range_err) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_pop = 1'b1;
          cmd_o.emit_st  = ST_RANGE;
          state_d        = S_IDLE;
        end else if (sts_i.len_zero) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_pop = 1'b1;
          cmd_o.emit_st  = ST_COMPLETED;
          state_d        = S_IDLE;
        end else begin
          state_d = S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd_o.byte_step = 1'b1;
        if (sts_i.byte_last) begin
          if (sts_i.ent_write) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_pop = 1'b1;
            cmd_o.emit_st  = ST_COMPLETED;
            state_d        = S_IDLE;
          end else begin
            state_d = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        // last read byte lands this cycle
        cmd_o.emit     = 1'b1;
        cmd_o.emit_pop = 1'b1;
        cmd_o.emit_st  = ST_COMPLETED;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/cbmt_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbmt_dp
// Credits, request queue memory, byte store memory and result registers.
// ----------------------------------------------------------------------------
module cbmt_dp
  import cbmt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctl_cmd_t          cmd_i,
  output dp_sts_t                sts_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CNT_W-1:0]  cfg_wdata_i,
  input  wire logic              is_write_i,
  input  wire logic [7:0]        addr_i,
  input  wire logic [2:0]        length_i,
  input  wire logic [31:0]       wdata_i,
  output logic                   done_o,
  output logic [2:0]             status_o,
  output logic [CNT_W-1:0]       credits_left_o,
  output logic [CNT_W-1:0]       occupancy_o,
  output logic                   credit_returned_o,
  output logic [31:0]            rdata_o,
  output logic                   done_was_write_o
);

  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int AW    = $clog2(STORE_BYTES);
  localparam int SUM_W = (AW + 1 > 9) ? AW + 1 : 9;
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int LIM_CAP = (QUEUE_DEPTH > CNT_MAX) ? CNT_MAX : QUEUE_DEPTH;
  localparam int LIM_RST = (LIMIT_RST > LIM_CAP) ? LIM_CAP : LIMIT_RST;
  localparam logic [CNT_W-1:0] LIM_CAP_C = CNT_W'(LIM_CAP);
  localparam logic [CNT_W-1:0] LIM_RST_C = CNT_W'(LIM_RST);
  localparam logic [CNT_W-1:0] CNT_MAX_C = CNT_W'(CNT_MAX);
  localparam logic [QW-1:0]    PTR_LAST  = QW'(QUEUE_DEPTH - 1);
  localparam logic [AW-1:0]    CLR_LAST  = AW'(STORE_BYTES - 1);
  localparam logic [SUM_W-1:0] STORE_END = SUM_W'(STORE_BYTES);
  localparam logic [2:0]       LEN_MAX   = 3'(BYTES_MAX);

  // ---------------- credits and queue pointers ----------------
  logic [CNT_W-1:0] lim_q, lim_d, credit_q, credit_d, count_q, count_d;
  logic [QW-1:0]    head_q, tail_q;
  logic [AW-1:0]    clr_addr_q;

  always_comb begin
    lim_d = (cfg_wdata_i > LIM_CAP_C) ? LIM_CAP_C : cfg_wdata_i;
    credit_d = credit_q;
    count_d  = count_q;
    if (cfg_we_i) begin
      credit_d = lim_d;
    end else if (cmd_i.spend) begin
      credit_d = credit_q - 1'b1;
    end else if (cmd_i.pop && credit_q != CNT_MAX_C) begin
      credit_d = credit_q + 1'b1;
    end
    if (cmd_i.enq) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q      <= LIM_RST_C;
      credit_q   <= LIM_RST_C;
      count_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      clr_addr_q <= '0;
    end else begin
      if (cfg_we_i) lim_q <= lim_d;
      credit_q <= credit_d;
      count_q  <= count_d;
      if (cmd_i.enq) tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
      if (cmd_i.pop) head_q <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
      if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // ---------------- request queue memory ----------------
  req_t qmem [QUEUE_DEPTH];
  req_t ent_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq) begin
      qmem[tail_q] <= '{is_write: is_write_i, addr: addr_i,
                        length: length_i, wdata: wdata_i};
    end
    if (cmd_i.pop) ent_q <= qmem[head_q];
  end

  // ---------------- byte store memory ----------------
  logic [7:0]       smem [STORE_BYTES];
  logic [1:0]       idx_q, cap_idx_q;
  logic             cap_q;
  logic [7:0]       rd_byte_q;
  logic [31:0]      acc_q, acc_d;
  logic [SUM_W-1:0] baddr;
  logic [SUM_W-1:0] end_addr;
  logic [AW-1:0]    waddr;
  logic             we;
  logic [7:0]       wbyte;

  assign baddr    = SUM_W'(ent_q.addr) + SUM_W'(idx_q);
  assign end_addr = SUM_W'(ent_q.addr) + SUM_W'(ent_q.length);
  assign we       = cmd_i.clr_step || (cmd_i.byte_step && ent_q.is_write);
  assign waddr    = cmd_i.clr_step ? clr_addr_q : baddr[AW-1:0];
  assign wbyte    = cmd_i.clr_step ? 8'h00 : ent_q.wdata[{idx_q, 3'b000} +: 8];

  always_ff @(posedge clk_i) begin
    if (we) smem[waddr] <= wbyte;
    if (cmd_i.byte_step && !ent_q.is_write) rd_byte_q <= smem[baddr[AW-1:0]];
  end

  always_comb begin
    acc_d = acc_q;
    if (cap_q) acc_d[{cap_idx_q, 3'b000} +: 8] = rd_byte_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 1'b0;
    end else begin
      cap_q <= cmd_i.byte_step && !ent_q.is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_idx_q <= idx_q;
    if (cmd_i.pop) begin
      idx_q <= '0;
      acc_q <= '0;
    end else begin
      if (cmd_i.byte_step) idx_q <= idx_q + 1'b1;
      acc_q <= acc_d;
    end
  end

  // ---------------- status ----------------
  always_comb begin
    sts_o.credit_zero = (credit_q == '0);
    sts_o.q_empty     = (count_q == '0);
    sts_o.q_full      = (count_q >= lim_q);
    sts_o.clr_last    = (clr_addr_q == CLR_LAST);
    sts_o.range_err   = (ent_q.length > LEN_MAX) || (end_addr > STORE_END);
    sts_o.len_zero    = (ent_q.length == '0);
    sts_o.byte_last   = ({1'b0, idx_q} == ent_q.length - 3'd1);
    sts_o.ent_write   = ent_q.is_write;
  end

  // ---------------- result registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o          <= cmd_i.emit_st;
      credits_left_o    <= credit_d;
      occupancy_o       <= count_d;
      credit_returned_o <= cmd_i.emit_pop;
      done_was_write_o  <= cmd_i.emit_pop && ent_q.is_write;
      rdata_o           <= (cmd_i.emit_pop && cmd_i.emit_st == ST_COMPLETED &&
                            !ent_q.is_write) ? acc_d : '0;
    end
  end

endmodule
`default_nettype wire

/* rtl/credit_buffered_memory_target.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// credit_buffered_memory_target
// Credit counter and bounded request queue in front of a byte store.
// ----------------------------------------------------------------------------
// Usage: present an item with start high; it is taken at the clock edge where
// busy is low. Every item yields exactly one result, shown on the result ports
// for one cycle with done_o high. The receiver cannot stall results, so it
// must take done_o as it comes. After reset the byte store is cleared, one
// byte per cycle, while busy stays high (configuration writes are still
// taken). A request item (cmd 0) or a drain on an empty queue finishes with
// busy staying low, so such items can follow each other every cycle; the
// result shows on the cycle after acceptance. A drain that pops an entry goes
// through the single-byte port of the store one byte per cycle: the entry is
// fetched, out-of-range and zero-length entries then finish, writes step
// through their bytes, reads step through their bytes and a tail state; the
// result shows in the first cycle with busy low again.
// ----------------------------------------------------------------------------
module credit_buffered_memory_target
  import cbmt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // item channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cmd_i,
  input  wire logic              is_write_i,
  input  wire logic [7:0]        addr_i,
  input  wire logic [2:0]        length_i,
  input  wire logic [31:0]       wdata_i,
  // buffer_limit register
  input  wire logic              cfg_we_i,
  input  wire logic [CNT_W-1:0]  cfg_wdata_i,
  // result channel
  output logic                   done_o,
  output logic [2:0]             status_o,
  output logic [CNT_W-1:0]       credits_left_o,
  output logic [CNT_W-1:0]       occupancy_o,
  output logic                   credit_returned_o,
  output logic [31:0]            rdata_o,
  output logic                   done_was_write_o
);

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;
  logic     start_ok;

  // controller only acts on start in its idle state; start is also gated with busy here
  assign start_ok = start && !busy;

  cbmt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start_ok),
    .cmd_i  (cmd_i),
    .sts_i  (dp_sts),
    .busy   (busy),
    .cmd_o  (ctl_cmd)
  );

  cbmt_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ctl_cmd),
    .sts_o             (dp_sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .is_write_i        (is_write_i),
    .addr_i            (addr_i),
    .length_i          (length_i),
    .wdata_i           (wdata_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .credits_left_o    (credits_left_o),
    .occupancy_o       (occupancy_o),
    .credit_returned_o (credit_returned_o),
    .rdata_o           (rdata_o),
    .done_was_write_o  (done_was_write_o)
  );

  // ---------------- assertions ----------------
  // request items answer on the very next cycle
  a_req_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_REQUEST) |=> done_o)
    else $error("request item without result on next cycle");

  // a returned credit only comes with a popped entry's status
  a_ret_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && credit_returned_o) |->
      (status_o == ST_COMPLETED || status_o == ST_RANGE))
    else $error("credit returned with wrong status");

  // read data is zero except for a completed read
  a_rdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_COMPLETED || done_was_write_o)) |-> (rdata_o == '0))
    else $error("nonzero read data on non-read result");

  // queue occupancy stays within the physical queue
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (32'(occupancy_o) <= QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

endmodule
`default_nettype wire
